// File: hw/rtl/gms_pkg.sv
// ----------------------------------------------------------------------------
// Gesture majority stabilizer package
// Shared widths, register codes and channel payload types.
// ----------------------------------------------------------------------------
package gms_pkg;

	localparam int LABEL_W = 4;
	localparam int CONF_W  = 17;
	localparam int DELTA_W = 18;
	localparam int THR_W   = 5;
	localparam int DB_W    = 17;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam int Q_ONE            = 65536;
	localparam int Q_THREE_QUARTERS = 49152;

	localparam logic [THR_W-1:0]   THR_RESET = 5'd3;
	localparam logic [DB_W-1:0]    DB_RESET  = 17'd1311;
	localparam logic [LABEL_W-1:0] CONT_A_RESET = 4'd1;
	localparam logic [LABEL_W-1:0] CONT_B_RESET = 4'd2;

	localparam logic [1:0] REG_CONFIRM_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_DELTA_DEADBAND    = 2'd1;
	localparam logic [1:0] REG_CONT_LABEL_A      = 2'd2;
	localparam logic [1:0] REG_CONT_LABEL_B      = 2'd3;

	typedef struct packed {
		logic               hand_mode;
		logic [LABEL_W-1:0] gesture_label;
		logic [CONF_W-1:0]  gesture_confidence;
	} gms_in_t;

	typedef struct packed {
		logic [LABEL_W-1:0] stable_label;
		logic [CONF_W-1:0]  stable_confidence;
	} gms_out_t;

	typedef struct packed {
		logic               valid;
		logic [LABEL_W-1:0] label;
		logic [CONF_W-1:0]  conf;
	} win_entry_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

// File: hw/rtl/gms_in_if.sv
// ----------------------------------------------------------------------------
// Gesture input channel
// Valid/ready channel carrying one raw gesture item per transfer.
// ----------------------------------------------------------------------------
interface gms_in_if import gms_pkg::*; ();

	logic    valid;
	logic    ready;
	gms_in_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);

endinterface

// File: hw/rtl/gms_out_if.sv
// ----------------------------------------------------------------------------
// Stable gesture output channel
// Valid/ready channel carrying one published gesture per transfer.
// ----------------------------------------------------------------------------
interface gms_out_if import gms_pkg::*; ();

	logic     valid;
	logic     ready;
	gms_out_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);

endinterface

// File: hw/rtl/gms_win_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// One entry of the sliding label window: shifts from its newer neighbor,
// matches its label against the probe and forwards the newest matching
// confidence along the chain.
// ----------------------------------------------------------------------------
module gms_win_cell import gms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctrl_t         ctrl,
	input  win_entry_t         nbr,
	output win_entry_t         entry,
	input  logic [LABEL_W-1:0] probe,
	output logic               match,
	input  logic [CONF_W-1:0]  conf_in,
	output logic [CONF_W-1:0]  conf_out
);

	logic               valid_q;
	logic [LABEL_W-1:0] label_q;
	logic [CONF_W-1:0]  conf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= nbr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			label_q <= nbr.label;
			conf_q  <= nbr.conf;
		end
	end

	assign entry.valid = valid_q;
	assign entry.label = label_q;
	assign entry.conf  = conf_q;

	assign match    = valid_q && (label_q == probe);
	assign conf_out = match ? conf_q : conf_in;

endmodule

// File: hw/rtl/gms_div.sv
// ----------------------------------------------------------------------------
// Rounding divider
// Restoring divider, one quotient bit per cycle, computing
// (dividend + divisor/2) / divisor for a small unsigned divisor.
// ----------------------------------------------------------------------------
module gms_div #(
	parameter int DW = 20,
	parameter int NW = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] acc_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [NW:0]   rs;
	logic          qbit;
	logic [NW:0]   rs_sub;

	assign rs     = {rem_q, acc_q[DW-1]};
	assign qbit   = rs >= {1'b0, div_q};
	assign rs_sub = rs - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend + DW'(divisor >> 1);
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			acc_q <= {acc_q[DW-2:0], qbit};
			rem_q <= qbit ? rs_sub[NW-1:0] : rs[NW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

endmodule

// File: hw/rtl/gesture_majority_stabilizer_unit.sv
// ----------------------------------------------------------------------------
// Gesture majority stabilizer
// Majority vote over a sliding window of gesture labels, with a moving
// average deadband on the confidence of continuous labels.
//
//   Channel  Modport  Payload                                        Role
//   gesture  sink     hand_mode, gesture_label, gesture_confidence   raw items
//   stable   source   stable_label, stable_confidence                published
//   APB      slave    four registers at byte addresses 0, 4, 8, 12   config
//
// An item is taken only in the idle state. A vote walks the window cells, one
// cell per cycle. A continuous item adds the rounding divider, one quotient
// bit per cycle. An item with hand_mode low clears the state. The result sits
// in an output register, so the next item is taken while a result waits for
// its transfer.
// Reset clears all control state and loads the register defaults.
// ----------------------------------------------------------------------------
module gesture_majority_stabilizer_unit import gms_pkg::*; #(
	parameter int WINDOW       = 8,
	parameter int DELTA_DEPTH  = 3,
	parameter int MAX_DISTINCT = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	gms_in_if.sink            gesture,
	gms_out_if.source         stable
);

	localparam int JW      = $clog2(WINDOW);
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int RW      = $clog2(MAX_DISTINCT + 1);
	localparam int NW      = $clog2(DELTA_DEPTH + 1);
	localparam int SUM_W   = DELTA_W + $clog2(DELTA_DEPTH) + 1;
	localparam int DIFF_W  = DELTA_W + 1;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_VOTE   = 8'b0000_0010,
		S_PICK   = 8'b0000_0100,
		S_ACT    = 8'b0000_1000,
		S_DSTART = 8'b0001_0000,
		S_DIV    = 8'b0010_0000,
		S_DECIDE = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [THR_W-1:0]   thr_q;
	logic [DB_W-1:0]    db_q;
	logic [LABEL_W-1:0] cont_a_q;
	logic [LABEL_W-1:0] cont_b_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			db_q     <= DB_RESET;
			cont_a_q <= CONT_A_RESET;
			cont_b_q <= CONT_B_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_CONFIRM_THRESHOLD: thr_q    <= pwdata[THR_W-1:0];
				REG_DELTA_DEADBAND:    db_q     <= pwdata[DB_W-1:0];
				REG_CONT_LABEL_A:      cont_a_q <= pwdata[LABEL_W-1:0];
				REG_CONT_LABEL_B:      cont_b_q <= pwdata[LABEL_W-1:0];
				default:               thr_q    <= thr_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_CONFIRM_THRESHOLD: prdata = DATA_W'(thr_q);
			REG_DELTA_DEADBAND:    prdata = DATA_W'(db_q);
			REG_CONT_LABEL_A:      prdata = DATA_W'(cont_a_q);
			REG_CONT_LABEL_B:      prdata = DATA_W'(cont_b_q);
			default:               prdata = '0;
		endcase
	end

	logic in_xfer;
	logic [CONF_W-1:0] conf_sat;
	logic clear_all;

	assign gesture.ready = (state_q == S_IDLE);
	assign in_xfer       = gesture.valid && gesture.ready;
	assign clear_all     = in_xfer && !gesture.data.hand_mode;
	assign conf_sat      = (gesture.data.gesture_confidence > CONF_W'(Q_ONE)) ?
		CONF_W'(Q_ONE) : gesture.data.gesture_confidence;

	// Window cells: index 0 is the oldest slot, the newest item enters at the top.
	cell_ctrl_t         cell_ctrl;
	win_entry_t         new_entry;
	win_entry_t         cell_out [WINDOW];
	logic [WINDOW-1:0]  match;
	logic [CONF_W-1:0]  conf_chain [WINDOW+1];
	logic [LABEL_W-1:0] probe;

	logic [JW-1:0]      j_q;
	logic [RW-1:0]      rank_q;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   best_count_q;
	logic [LABEL_W-1:0] best_label_q;

	assign cell_ctrl.shift = in_xfer && gesture.data.hand_mode;
	assign cell_ctrl.clear = clear_all;
	assign new_entry.valid = 1'b1;
	assign new_entry.label = gesture.data.gesture_label;
	assign new_entry.conf  = conf_sat;
	assign conf_chain[0]   = '0;
	assign probe = (state_q == S_VOTE) ? cell_out[j_q].label : best_label_q;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		win_entry_t nbr;
		if (i == WINDOW - 1) begin : g_top
			assign nbr = new_entry;
		end else begin : g_mid
			assign nbr = cell_out[i+1];
		end
		gms_win_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.nbr      (nbr),
			.entry    (cell_out[i]),
			.probe    (probe),
			.match    (match[i]),
			.conf_in  (conf_chain[i]),
			.conf_out (conf_chain[i+1])
		);
	end

	logic             earlier;
	logic [CNT_W-1:0] cand_count;
	logic             first_seen;

	always_comb begin
		earlier = 1'b0;
		for (int i = 0; i < WINDOW; i++) begin
			if (JW'(i) < j_q) begin
				earlier = earlier | match[i];
			end
		end
	end

	assign cand_count = CNT_W'($countones(match));
	assign first_seen = cell_out[j_q].valid && !earlier;

	logic                      confirmed_q;
	logic [CONF_W-1:0]         win_conf_q;
	logic                      last_valid_q;
	logic [LABEL_W-1:0]        last_label_q;
	logic signed [DELTA_W-1:0] last_sent_q;

	logic confirmed;
	logic changed;
	logic continuous;

	assign confirmed = (32'(fill_q) >= 32'(thr_q)) && (best_count_q != '0) &&
		(32'(best_count_q) >= 32'(thr_q));
	assign changed    = !last_valid_q || (best_label_q != last_label_q);
	assign continuous = (best_label_q == cont_a_q) || (best_label_q == cont_b_q);

	// Delta window and running sum.
	logic signed [DELTA_W-1:0] delta_q [DELTA_DEPTH];
	logic [NW-1:0]             dfill_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [DELTA_W-1:0] delta_new;
	logic                      dfull;
	logic signed [SUM_W-1:0]   evict;
	logic                      push;

	assign delta_new = $signed({1'b0, win_conf_q}) - $signed(DELTA_W'(Q_THREE_QUARTERS));
	assign dfull     = (dfill_q == NW'(DELTA_DEPTH));
	assign evict     = dfull ? SUM_W'(delta_q[0]) : '0;
	assign push      = (state_q == S_ACT) && confirmed_q && continuous;

	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < DELTA_DEPTH - 1; i++) begin
				delta_q[i] <= delta_q[i+1];
			end
			delta_q[DELTA_DEPTH-1] <= delta_new;
		end
	end

	logic              div_start;
	logic              div_done;
	logic [SUM_W-1:0]  quotient;
	logic [SUM_W-1:0]  sum_mag;
	logic              sum_neg_q;

	assign div_start = (state_q == S_DSTART);
	assign sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	gms_div #(
		.DW (SUM_W),
		.NW (NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_mag),
		.divisor  (dfill_q),
		.done     (div_done),
		.quotient (quotient)
	);

	logic signed [SUM_W-1:0]   avg_full;
	logic signed [DELTA_W-1:0] avg_d;
	logic signed [DIFF_W-1:0]  diff;
	logic [DIFF_W-1:0]         abs_diff;
	logic                      publish;
	logic [DELTA_W-1:0]        pub_conf;

	assign avg_full = sum_neg_q ? -$signed(quotient) : $signed(quotient);
	assign avg_d    = DELTA_W'(avg_full);
	assign diff     = DIFF_W'(avg_d) - DIFF_W'(last_sent_q);
	assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign publish  = changed || (abs_diff > DIFF_W'(db_q));
	assign pub_conf = DELTA_W'(Q_THREE_QUARTERS) + avg_d;

	logic [LABEL_W-1:0] res_label_q;
	logic [CONF_W-1:0]  res_conf_q;
	logic               out_valid_q;
	gms_out_t           out_data_q;
	logic               out_free;

	assign out_free = !out_valid_q || stable.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			j_q          <= '0;
			rank_q       <= '0;
			fill_q       <= '0;
			dfill_q      <= '0;
			sum_q        <= '0;
			last_valid_q <= 1'b0;
			last_label_q <= '0;
			last_sent_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (clear_all) begin
						fill_q       <= '0;
						dfill_q      <= '0;
						sum_q        <= '0;
						last_valid_q <= 1'b0;
						last_label_q <= '0;
						last_sent_q  <= '0;
					end else if (in_xfer) begin
						if (fill_q != CNT_W'(WINDOW)) begin
							fill_q <= fill_q + 1'b1;
						end
						j_q     <= '0;
						rank_q  <= '0;
						state_q <= S_VOTE;
					end
				end
				S_VOTE: begin
					if (first_seen && (rank_q != RW'(MAX_DISTINCT))) begin
						rank_q <= rank_q + 1'b1;
					end
					j_q <= j_q + 1'b1;
					if (j_q == JW'(WINDOW - 1)) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					state_q <= S_ACT;
				end
				S_ACT: begin
					if (!confirmed_q) begin
						state_q <= S_IDLE;
					end else if (!continuous) begin
						dfill_q     <= '0;
						sum_q       <= '0;
						last_sent_q <= '0;
						if (changed) begin
							last_valid_q <= 1'b1;
							last_label_q <= best_label_q;
							state_q      <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						sum_q <= sum_q + SUM_W'(delta_new) - evict;
						if (!dfull) begin
							dfill_q <= dfill_q + 1'b1;
						end
						state_q <= S_DSTART;
					end
				end
				S_DSTART: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (publish) begin
						last_valid_q <= 1'b1;
						last_label_q <= best_label_q;
						last_sent_q  <= avg_d;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_VOTE && first_seen && (rank_q != RW'(MAX_DISTINCT)) &&
			((cand_count > best_count_q) || (j_q == '0))) begin
			best_count_q <= cand_count;
			best_label_q <= cell_out[j_q].label;
		end else if (state_q == S_IDLE && in_xfer) begin
			best_count_q <= '0;
		end
		if (state_q == S_PICK) begin
			win_conf_q  <= conf_chain[WINDOW];
			confirmed_q <= confirmed;
		end
		if (state_q == S_DSTART) begin
			sum_neg_q <= sum_q[SUM_W-1];
		end
		if (state_q == S_ACT) begin
			res_label_q <= best_label_q;
			res_conf_q  <= win_conf_q;
		end else if (state_q == S_DECIDE) begin
			res_conf_q <= pub_conf[CONF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (stable.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_data_q.stable_label      <= res_label_q;
			out_data_q.stable_confidence <= res_conf_q;
		end
	end

	assign stable.valid = out_valid_q;
	assign stable.data  = out_data_q;

endmodule
